// File: hdl/dbwc_pkg.sv
// Shared types and constants for the delay-based window controller.
// No dependencies; used by dbwc_div and delay_based_window_controller.
`default_nettype none

package dbwc_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TARGET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREASE_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DECREASE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT   = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_INITIAL_WINDOW = 16'd10;
  localparam logic [15:0] RST_MAX_WINDOW     = 16'd256;
  localparam logic [31:0] RST_DELAY_TARGET   = 32'd25000;
  localparam logic [16:0] RST_INCREASE_STEP  = 17'd65536;
  localparam logic [16:0] RST_DECREASE_GAIN  = 17'd52429;
  localparam logic [16:0] RST_MAX_DECREASE   = 17'd32768;
  localparam logic [7:0]  RST_TIMEOUT_LIMIT  = 8'd5;

  // Event codes
  localparam logic [1:0] OP_ACK     = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  // Q16 unity and the divider operand width
  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam int unsigned DIV_W   = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hdl/dbwc_div.sv
// Restoring divider, one quotient bit per cycle, shared by increase and decrease paths.
// Depends on dbwc_pkg (DIV_W, div_stat_t).
`default_nettype none

module dbwc_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned CNT_W = $clog2(NUM_W + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [CNT_W-1:0]            iters_i,
  input  wire logic [dbwc_pkg::DIV_W-1:0]  rem_init_i,
  input  wire logic [dbwc_pkg::DIV_W-1:0]  divisor_i,
  input  wire logic [NUM_W-1:0]            num_i,
  output dbwc_pkg::div_stat_t              stat_o,
  output logic      [NUM_W-1:0]            quotient_o
);

  logic [dbwc_pkg::DIV_W-1:0] rem_q;
  logic [dbwc_pkg::DIV_W-1:0] dvs_q;
  logic [NUM_W-1:0]           num_q;
  logic [NUM_W-1:0]           quo_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [dbwc_pkg::DIV_W:0]   shifted;
  logic [dbwc_pkg::DIV_W:0]   trial;
  logic                       fits;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = ~trial[dbwc_pkg::DIV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvs_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= rem_init_i;
        dvs_q  <= divisor_i;
        num_q  <= num_i;
        quo_q  <= '0;
        cnt_q  <= iters_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? trial[dbwc_pkg::DIV_W-1:0] : shifted[dbwc_pkg::DIV_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        quo_q <= {quo_q[NUM_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

// File: hdl/dbwc_mul.sv
// Shared multiplier with a registered product.
// No package dependencies.
`default_nettype none

module dbwc_mul #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 17
) (
  input  wire logic               clk_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic      [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: hdl/delay_based_window_controller.sv
// Top level: configuration registers, window state and the sequencer that drives
// the shared divider (dbwc_div) and multiplier (dbwc_mul). Uses dbwc_pkg.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+------------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | opcode, delay_ns, now_ns
//   out     | source    | out_valid_o / out_stall_i | window_packets, fraction, flags
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Work per word: init, timeout and gated-off events go straight to the result; a timeout
// decrease passes once through the multiplier; an increase runs NUM_W divider steps at
// one quotient bit per cycle; a delay decrease runs 16 divider steps (none at zero target)
// and then two passes through the multiplier. One word is in work at a time;
// in_stall_o is high until the result is placed in the output register, which a
// stalled sink may still hold while the next word is taken. Reset is asynchronous,
// active low, and brings registers to their documented defaults; cfg_ready_o is
// always high.
`default_nettype none

module delay_based_window_controller #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned TIME_BITS     = 48
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // item in
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      opcode_i,
  input  wire logic [31:0]                     delay_ns_i,
  input  wire logic [47:0]                     now_ns_i,
  // result out
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [15:0]                     window_packets_o,
  output logic      [15:0]                     window_fraction_q16_o,
  output logic                                 decreased_o,
  output logic                                 window_was_reset_o,
  // configuration
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dbwc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dbwc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned WW    = 16 + FRACTION_BITS;
  localparam int unsigned SH_UP = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
  localparam int unsigned SH_DN = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam int unsigned NUM_W = 17 + SH_UP;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned P_W   = WW + 17;
  localparam logic [WW-1:0] ONE_FP = WW'(1) << FRACTION_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INC_DIV,
    ST_DEC_DIV,
    ST_MUL_R,
    ST_FACTOR,
    ST_MUL_W,
    ST_SCALE,
    ST_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic        en_q;
  logic [15:0] init_win_q;
  logic [15:0] max_win_q;
  logic [31:0] target_q;
  logic [16:0] inc_q;
  logic [16:0] gain_q;
  logic [16:0] maxdec_q;
  logic [7:0]  limit_q;

  // controller state
  logic [WW-1:0]        win_q;
  logic [TIME_BITS-1:0] last_dec_q;
  logic [31:0]          rtt_q;
  logic [7:0]           tocnt_q;

  // current word and scratch
  logic [1:0]           op_q;
  logic [31:0]          delay_q;
  logic [TIME_BITS-1:0] now_q;
  logic [16:0]          r_q;
  logic [16:0]          factor_q;
  logic                 dec_q;
  logic                 wrst_q;

  // result register
  logic        out_valid_q;
  logic [15:0] out_pk_q;
  logic [15:0] out_frac_q;
  logic        out_dec_q;
  logic        out_wrst_q;

  // datapath
  logic [15:0]          win_pk;
  logic [15:0]          n_pk;
  logic [15:0]          load_pk;
  logic [15:0]          cap_pk;
  logic [WW-1:0]        load_fp;
  logic [WW-1:0]        cap_fp;
  logic [NUM_W-1:0]     inc_num;
  logic                 ack_en;
  logic                 to_en;
  logic                 below;
  logic [TIME_BITS-1:0] since_dec;
  logic                 gate;
  logic [7:0]           tocnt_next;
  logic                 to_reset;
  logic [31:0]          excess;
  logic signed [17:0]   f1;
  logic signed [17:0]   f2;
  logic signed [17:0]   fmax;
  logic [16:0]          f1_sel;
  logic [16:0]          f2_sel;
  logic [WW:0]          win_sum;
  logic [WW-1:0]        win_inc;
  logic [WW-1:0]        scaled;
  logic [WW-1:0]        win_scaled;
  logic [WW-1:0]        frac_wide;

  // shared units
  logic                       div_start;
  logic [CNT_W-1:0]           div_iters;
  logic [dbwc_pkg::DIV_W-1:0] div_rem;
  logic [dbwc_pkg::DIV_W-1:0] div_dvs;
  logic [NUM_W-1:0]           div_num;
  dbwc_pkg::div_stat_t        div_stat;
  logic [NUM_W-1:0]           div_quo;
  logic [WW-1:0]              mul_a;
  logic [16:0]                mul_b;
  logic [P_W-1:0]             mul_p;

  assign win_pk  = win_q[WW-1:FRACTION_BITS];
  assign n_pk    = (win_pk == 16'd0) ? 16'd1 : win_pk;
  assign load_pk = en_q ? init_win_q : max_win_q;
  assign cap_pk  = (max_win_q == 16'd0) ? 16'd1 : max_win_q;
  assign load_fp = WW'((load_pk == 16'd0) ? 16'd1 : load_pk) << FRACTION_BITS;
  assign cap_fp  = WW'(cap_pk) << FRACTION_BITS;
  // step numerator aligned to the window's fraction bits
  assign inc_num = (NUM_W'(inc_q) << SH_UP) >> SH_DN;

  assign ack_en     = (op_q == dbwc_pkg::OP_ACK) && en_q;
  assign to_en      = (op_q == dbwc_pkg::OP_TIMEOUT) && en_q;
  assign below      = delay_q < target_q;
  assign since_dec  = now_q - last_dec_q;
  assign gate       = since_dec >= TIME_BITS'(rtt_q);
  assign tocnt_next = (tocnt_q == 8'hFF) ? tocnt_q : tocnt_q + 8'd1;
  assign to_reset   = tocnt_next >= limit_q;
  assign excess     = delay_q - target_q;

  // factors are signed Q16; negative clamps to zero
  assign f2     = $signed({1'b0, dbwc_pkg::Q16_ONE}) - $signed({1'b0, maxdec_q});
  assign f2_sel = f2[17] ? 17'd0 : f2[16:0];
  assign f1     = $signed({1'b0, dbwc_pkg::Q16_ONE}) - $signed({1'b0, mul_p[32:16]});
  assign fmax   = (f1 > f2) ? f1 : f2;
  assign f1_sel = fmax[17] ? 17'd0 : fmax[16:0];

  assign win_sum    = {1'b0, win_q} + (WW+1)'(div_quo);
  assign win_inc    = (win_sum > {1'b0, cap_fp}) ? cap_fp : win_sum[WW-1:0];
  // factor never exceeds one, so the scaled window fits
  assign scaled     = mul_p[WW+15:16];
  assign win_scaled = (scaled < ONE_FP) ? ONE_FP : scaled;

  assign frac_wide = {win_q[FRACTION_BITS-1:0], 16'b0};

  // divider setup: increase divides by the packet count, decrease by the delay
  assign div_start = (state_q == ST_DECIDE) && ack_en &&
                     (below || (gate && (target_q != 32'd0)));
  assign div_iters = below ? CNT_W'(NUM_W) : CNT_W'(16);
  assign div_rem   = below ? '0 : excess;
  assign div_dvs   = below ? {16'd0, n_pk} : delay_q;
  assign div_num   = below ? inc_num : '0;

  assign mul_a = (state_q == ST_MUL_R) ? WW'(r_q) : win_q;
  assign mul_b = (state_q == ST_MUL_R) ? gain_q : factor_q;

  dbwc_div #(
    .NUM_W (NUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .iters_i    (div_iters),
    .rem_init_i (div_rem),
    .divisor_i  (div_dvs),
    .num_i      (div_num),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  dbwc_mul #(
    .A_W (WW),
    .B_W (17)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b1;
      init_win_q  <= dbwc_pkg::RST_INITIAL_WINDOW;
      max_win_q   <= dbwc_pkg::RST_MAX_WINDOW;
      target_q    <= dbwc_pkg::RST_DELAY_TARGET;
      inc_q       <= dbwc_pkg::RST_INCREASE_STEP;
      gain_q      <= dbwc_pkg::RST_DECREASE_GAIN;
      maxdec_q    <= dbwc_pkg::RST_MAX_DECREASE;
      limit_q     <= dbwc_pkg::RST_TIMEOUT_LIMIT;
      win_q       <= WW'(dbwc_pkg::RST_INITIAL_WINDOW) << FRACTION_BITS;
      last_dec_q  <= '0;
      rtt_q       <= '0;
      tocnt_q     <= '0;
      op_q        <= '0;
      delay_q     <= '0;
      now_q       <= '0;
      r_q         <= '0;
      factor_q    <= '0;
      dec_q       <= 1'b0;
      wrst_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_pk_q    <= '0;
      out_frac_q  <= '0;
      out_dec_q   <= 1'b0;
      out_wrst_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          dbwc_pkg::CFG_CONTROL_ENABLE: en_q       <= cfg_data_i[0];
          dbwc_pkg::CFG_INITIAL_WINDOW: init_win_q <= cfg_data_i[15:0];
          dbwc_pkg::CFG_MAX_WINDOW:     max_win_q  <= cfg_data_i[15:0];
          dbwc_pkg::CFG_DELAY_TARGET:   target_q   <= cfg_data_i[31:0];
          dbwc_pkg::CFG_INCREASE_STEP:  inc_q      <= cfg_data_i[16:0];
          dbwc_pkg::CFG_DECREASE_GAIN:  gain_q     <= cfg_data_i[16:0];
          dbwc_pkg::CFG_MAX_DECREASE:   maxdec_q   <= cfg_data_i[16:0];
          dbwc_pkg::CFG_TIMEOUT_LIMIT:  limit_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      // the emit state reloads the result register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            delay_q <= delay_ns_i;
            now_q   <= TIME_BITS'(now_ns_i);
            dec_q   <= 1'b0;
            wrst_q  <= 1'b0;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (op_q == dbwc_pkg::OP_INIT) begin
            win_q      <= load_fp;
            last_dec_q <= '0;
            rtt_q      <= '0;
            tocnt_q    <= '0;
            state_q    <= ST_EMIT;
          end else if (ack_en) begin
            tocnt_q <= '0;
            rtt_q   <= delay_q;
            if (below) begin
              state_q <= ST_INC_DIV;
            end else if (gate) begin
              last_dec_q <= now_q;
              dec_q      <= 1'b1;
              if (target_q == 32'd0) begin
                // excess equals the whole delay: ratio is one, or zero for no delay
                r_q     <= (delay_q != 32'd0) ? dbwc_pkg::Q16_ONE : 17'd0;
                state_q <= ST_MUL_R;
              end else begin
                state_q <= ST_DEC_DIV;
              end
            end else begin
              state_q <= ST_EMIT;
            end
          end else if (to_en) begin
            tocnt_q <= tocnt_next;
            if (to_reset) begin
              win_q   <= ONE_FP;
              wrst_q  <= 1'b1;
              state_q <= ST_EMIT;
            end else if (gate) begin
              factor_q <= f2_sel;
              dec_q    <= 1'b1;
              state_q  <= ST_MUL_W;
            end else begin
              state_q <= ST_EMIT;
            end
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_INC_DIV: begin
          if (div_stat.done) begin
            win_q   <= win_inc;
            state_q <= ST_EMIT;
          end
        end
        ST_DEC_DIV: begin
          if (div_stat.done) begin
            r_q     <= div_quo[16:0];
            state_q <= ST_MUL_R;
          end
        end
        ST_MUL_R: begin
          state_q <= ST_FACTOR;
        end
        ST_FACTOR: begin
          factor_q <= f1_sel;
          state_q  <= ST_MUL_W;
        end
        ST_MUL_W: begin
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          win_q   <= win_scaled;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_pk_q    <= win_pk;
            out_frac_q  <= frac_wide[FRACTION_BITS+15:FRACTION_BITS];
            out_dec_q   <= dec_q;
            out_wrst_q  <= wrst_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o            = (state_q != ST_IDLE);
  assign cfg_ready_o           = 1'b1;
  assign out_valid_o           = out_valid_q;
  assign window_packets_o      = out_pk_q;
  assign window_fraction_q16_o = out_frac_q;
  assign decreased_o           = out_dec_q;
  assign window_was_reset_o    = out_wrst_q;

  // divider only runs while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_INC_DIV || state_q == ST_DEC_DIV))
    else $error("divider busy outside a divide state");

  // window never drops below one packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_pk != 16'd0)
    else $error("window integer part is zero");

  // an accepted word always occupies the sequencer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DECIDE))
    else $error("accepted word did not start processing");

  // a limit reset and a multiplicative decrease are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(decreased_o && window_was_reset_o))
    else $error("both decrease and reset flagged");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking bench for delay_based_window_controller: a queue-fed driver, a
// result monitor and a window predictor kept in step with every accepted word.
// Depends on dbwc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNKNOWN  = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         PHASES      = 8;
  localparam int         PHASE_WORDS = 180;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] delay;
    logic [47:0] stamp;
  } cc_event_t;

  typedef struct {
    logic [15:0] packets;
    logic [15:0] fraction;
    logic        decreased;
    logic        was_reset;
  } window_report_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic [1:0]                     opcode_i    = dbwc_pkg::OP_ACK;
  logic [31:0]                    delay_ns_i  = '0;
  logic [47:0]                    now_ns_i    = '0;
  logic                           out_stall_i = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic [dbwc_pkg::CFG_IDX_W-1:0] cfg_index_i = dbwc_pkg::CFG_CONTROL_ENABLE;
  logic [31:0]                    cfg_data_i  = '0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic [15:0]                    window_packets_o;
  logic [15:0]                    window_fraction_q16_o;
  logic                           decreased_o;
  logic                           window_was_reset_o;
  logic                           cfg_ready_o;

  // shadow registers, reset values
  logic        set_enable   = 1'b1;
  logic [15:0] set_init_win = dbwc_pkg::RST_INITIAL_WINDOW;
  logic [15:0] set_max_win  = dbwc_pkg::RST_MAX_WINDOW;
  logic [31:0] set_target   = dbwc_pkg::RST_DELAY_TARGET;
  logic [16:0] set_step     = dbwc_pkg::RST_INCREASE_STEP;
  logic [16:0] set_gain     = dbwc_pkg::RST_DECREASE_GAIN;
  logic [16:0] set_max_dec  = dbwc_pkg::RST_MAX_DECREASE;
  logic [7:0]  set_limit    = dbwc_pkg::RST_TIMEOUT_LIMIT;

  // predicted controller state
  logic [31:0] win_q16     = {dbwc_pkg::RST_INITIAL_WINDOW, 16'h0000};
  logic [47:0] last_cut_ns = '0;
  logic [31:0] last_rtt_ns = '0;
  logic [7:0]  timeout_run = '0;

  cc_event_t      event_feed[$];
  window_report_t expected_windows[$];
  window_report_t want;
  cc_event_t      next_word;
  int             words_unsent  = 0;
  int             mismatches    = 0;
  int             cycle_count   = 0;
  int             send_gap_pct  = 0;
  int             stall_pct     = 0;
  logic [47:0]    sim_now       = '0;

  delay_based_window_controller i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .opcode_i              (opcode_i),
    .delay_ns_i            (delay_ns_i),
    .now_ns_i              (now_ns_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .window_packets_o      (window_packets_o),
    .window_fraction_q16_o (window_fraction_q16_o),
    .decreased_o           (decreased_o),
    .window_was_reset_o    (window_was_reset_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic gate_open(input logic [47:0] stamp);
    logic [47:0] diff;
    diff = stamp - last_cut_ns;  // wraps when time runs backwards
    return diff >= {16'h0000, last_rtt_ns};
  endfunction

  function automatic logic [31:0] scaled(input logic [31:0] w, input longint factor);
    logic [63:0] prod;
    prod = (64'(w) * 64'(factor < 0 ? 0 : factor)) >> 16;
    if (prod < 64'h1_0000) prod = 64'h1_0000;
    return prod[31:0];
  endfunction

  task automatic advance_window(input logic [1:0] op, input logic [31:0] dly,
                                input logic [47:0] stamp);
    logic [63:0]    pk, step, cap, wide, ratio;
    longint         f_delay, f_floor;
    window_report_t r;
    r = '{default: '0};
    if (op == dbwc_pkg::OP_INIT) begin
      pk = set_enable ? 64'(set_init_win) : 64'(set_max_win);
      if (pk == 0) pk = 1;
      win_q16     = {pk[15:0], 16'h0000};
      last_cut_ns = '0;
      last_rtt_ns = '0;
      timeout_run = '0;
    end else if (op == dbwc_pkg::OP_ACK && set_enable) begin
      timeout_run = '0;
      if (dly < set_target) begin
        pk = 64'(win_q16[31:16]);
        if (pk == 0) pk = 1;
        step = (64'(set_step) << 16) / (pk << 16);
        cap  = 64'(set_max_win == 0 ? 16'd1 : set_max_win) << 16;
        wide = 64'(win_q16) + step;
        if (wide > cap) wide = cap;
        win_q16 = wide[31:0];
      end else if (gate_open(stamp)) begin
        ratio   = (dly != 0) ? ((64'(dly) - 64'(set_target)) << 16) / 64'(dly) : 64'd0;
        f_delay = 65536 - longint'((64'(set_gain) * ratio) >> 16);
        f_floor = 65536 - longint'(set_max_dec);
        win_q16 = scaled(win_q16, (f_delay > f_floor) ? f_delay : f_floor);
        last_cut_ns = stamp;
        r.decreased = 1'b1;
      end
      last_rtt_ns = dly;
    end else if (op == dbwc_pkg::OP_TIMEOUT && set_enable) begin
      if (timeout_run != 8'hFF) timeout_run++;
      if (timeout_run >= set_limit) begin
        win_q16     = 32'h0001_0000;
        r.was_reset = 1'b1;
      end else if (gate_open(stamp)) begin
        // timeout cut does not restamp the decrease time
        win_q16     = scaled(win_q16, 65536 - longint'(set_max_dec));
        r.decreased = 1'b1;
      end
    end
    r.packets  = win_q16[31:16];
    r.fraction = win_q16[15:0];
    expected_windows.insert(expected_windows.size(), r);
  endtask

  // driver: a word moves when valid is high and stall is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_window(opcode_i, delay_ns_i, now_ns_i);
        words_unsent--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (event_feed.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_word = event_feed.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= next_word.op;
          delay_ns_i <= next_word.delay;
          now_ns_i   <= next_word.stamp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_windows.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = expected_windows.pop_front();
          if (window_packets_o !== want.packets)
            flag_mismatch($sformatf("window_packets %0d, expected %0d",
                                    window_packets_o, want.packets));
          if (window_fraction_q16_o !== want.fraction)
            flag_mismatch($sformatf("window_fraction_q16 %h, expected %h",
                                    window_fraction_q16_o, want.fraction));
          if (decreased_o !== want.decreased)
            flag_mismatch($sformatf("decreased %b, expected %b", decreased_o, want.decreased));
          if (window_was_reset_o !== want.was_reset)
            flag_mismatch($sformatf("window_was_reset %b, expected %b",
                                    window_was_reset_o, want.was_reset));
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_event(input logic [1:0] op, input logic [31:0] dly,
                            input logic [47:0] stamp);
    cc_event_t ev;
    ev = '{op, dly, stamp};
    event_feed.insert(event_feed.size(), ev);
    words_unsent++;
  endtask

  task automatic wait_idle();
    while (words_unsent != 0 || expected_windows.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [dbwc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      dbwc_pkg::CFG_CONTROL_ENABLE: set_enable   = data[0];
      dbwc_pkg::CFG_INITIAL_WINDOW: set_init_win = data[15:0];
      dbwc_pkg::CFG_MAX_WINDOW:     set_max_win  = data[15:0];
      dbwc_pkg::CFG_DELAY_TARGET:   set_target   = data;
      dbwc_pkg::CFG_INCREASE_STEP:  set_step     = data[16:0];
      dbwc_pkg::CFG_DECREASE_GAIN:  set_gain     = data[16:0];
      dbwc_pkg::CFG_MAX_DECREASE:   set_max_dec  = data[16:0];
      dbwc_pkg::CFG_TIMEOUT_LIMIT:  set_limit    = data[7:0];
      default: ;
    endcase
  endtask

  // mostly acks around the target with a moving clock, timeout runs, some noise
  task automatic random_traffic(input int count);
    int          sent, roll, burst, run_cap;
    logic [63:0] span, d, adv;
    sent = 0;
    span = ((set_target >> 1) == 0) ? 64'd1 : 64'(set_target >> 1);
    run_cap = (set_limit == 0) ? 1 : ((set_limit > 8) ? 8 : int'(set_limit));
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        push_event(dbwc_pkg::OP_INIT, $urandom, sim_now);
        sent++;
      end else if (roll < 8) begin
        push_event(2'($urandom_range(3)), $urandom, {16'($urandom), 32'($urandom)});
        sent++;
      end else if (roll < 22) begin
        burst = $urandom_range(1, run_cap + 1);
        repeat (burst) begin
          sim_now += 48'($urandom_range(0, clamp32(span * 4)));
          push_event(dbwc_pkg::OP_TIMEOUT, $urandom, sim_now);
          sent++;
        end
      end else begin
        roll = $urandom_range(99);
        if (roll < 42) begin
          d = 64'($urandom_range(1, clamp32(span)));
          d = (64'(set_target) > d) ? 64'(set_target) - d : 64'd0;
        end else if (roll < 52) begin
          d = 64'(set_target);
        end else if (roll < 95) begin
          d = 64'(set_target) + 64'($urandom_range(1, clamp32(span * 6)));
        end else begin
          d = 64'($urandom);
        end
        if ($urandom_range(1) == 0) adv = 64'($urandom_range(0, clamp32(span >> 1)));
        else adv = 64'($urandom_range(0, clamp32(span * 4)));
        sim_now += adv[47:0];
        push_event(dbwc_pkg::OP_ACK, clamp32(d), sim_now);
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] p_en, p_init, p_max, p_target, p_step, p_gain, p_dec, p_limit;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: growth, clamped cut, closed gate, backwards time, limit
    push_event(dbwc_pkg::OP_ACK, 32'd0, 48'd100);
    push_event(dbwc_pkg::OP_ACK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_event(dbwc_pkg::OP_ACK, dbwc_pkg::RST_DELAY_TARGET, 48'hFFFF_FFFF_FFFF);
    push_event(dbwc_pkg::OP_TIMEOUT, 32'd0, 48'd0);
    repeat (5) push_event(dbwc_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 48'h8000_0000_0000);
    push_event(OP_UNKNOWN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_event(dbwc_pkg::OP_INIT, 32'd0, 48'd0);
    wait_idle();

    // control off: ack and timeout leave state, init loads the maximum
    cfg_write(dbwc_pkg::CFG_CONTROL_ENABLE, 32'd0);
    push_event(dbwc_pkg::OP_ACK, 32'd1, 48'd5);
    push_event(dbwc_pkg::OP_TIMEOUT, 32'd0, 48'd9);
    push_event(dbwc_pkg::OP_INIT, 32'd0, 48'd9);
    wait_idle();

    // zero windows, zero target and zero timeout limit
    cfg_write(dbwc_pkg::CFG_CONTROL_ENABLE, 32'd1);
    cfg_write(dbwc_pkg::CFG_INITIAL_WINDOW, 32'd0);
    cfg_write(dbwc_pkg::CFG_MAX_WINDOW, 32'd0);
    push_event(dbwc_pkg::OP_INIT, 32'd0, 48'd0);
    push_event(dbwc_pkg::OP_ACK, 32'd0, 48'd10);
    wait_idle();
    cfg_write(dbwc_pkg::CFG_DELAY_TARGET, 32'd0);
    cfg_write(dbwc_pkg::CFG_TIMEOUT_LIMIT, 32'd0);
    push_event(dbwc_pkg::OP_ACK, 32'd0, 48'd20);
    push_event(dbwc_pkg::OP_ACK, 32'd7, 48'd30);
    push_event(dbwc_pkg::OP_TIMEOUT, 32'd0, 48'd40);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 74; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 74; end
        default: begin send_gap_pct = 24; stall_pct = 24; end
      endcase
      case (p)
        0: begin
          p_en = 1; p_init = dbwc_pkg::RST_INITIAL_WINDOW; p_max = dbwc_pkg::RST_MAX_WINDOW;
          p_target = dbwc_pkg::RST_DELAY_TARGET; p_step = dbwc_pkg::RST_INCREASE_STEP;
          p_gain = dbwc_pkg::RST_DECREASE_GAIN; p_dec = dbwc_pkg::RST_MAX_DECREASE;
          p_limit = dbwc_pkg::RST_TIMEOUT_LIMIT;
        end
        2: begin
          p_en = 1; p_init = 1; p_max = 1; p_target = 1;
          p_step = 0; p_gain = dbwc_pkg::Q16_ONE; p_dec = dbwc_pkg::Q16_ONE; p_limit = 1;
        end
        3: begin
          p_en = 1; p_init = 16'hFFFF; p_max = 16'hFFFF; p_target = 32'hFFFF_FFFF;
          p_step = dbwc_pkg::Q16_ONE; p_gain = 0; p_dec = 0; p_limit = 8'hFF;
        end
        default: begin
          p_en     = (p == 4) ? 0 : 1;
          p_init   = $urandom_range(1, 40);
          p_max    = ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(8, 1000);
          p_target = $urandom_range(500, 200000);
          p_step   = $urandom_range(0, dbwc_pkg::Q16_ONE);
          p_gain   = $urandom_range(0, dbwc_pkg::Q16_ONE);
          p_dec    = $urandom_range(0, dbwc_pkg::Q16_ONE);
          p_limit  = (p == 6) ? 0 : $urandom_range(1, 8);
        end
      endcase
      cfg_write(dbwc_pkg::CFG_CONTROL_ENABLE, p_en);
      cfg_write(dbwc_pkg::CFG_INITIAL_WINDOW, p_init);
      cfg_write(dbwc_pkg::CFG_MAX_WINDOW, p_max);
      cfg_write(dbwc_pkg::CFG_DELAY_TARGET, p_target);
      cfg_write(dbwc_pkg::CFG_INCREASE_STEP, p_step);
      cfg_write(dbwc_pkg::CFG_DECREASE_GAIN, p_gain);
      cfg_write(dbwc_pkg::CFG_MAX_DECREASE, p_dec);
      cfg_write(dbwc_pkg::CFG_TIMEOUT_LIMIT, p_limit);
      sim_now = {16'($urandom), 32'($urandom)};
      push_event(dbwc_pkg::OP_INIT, $urandom, sim_now);
      // long timeout run so the counter hits its ceiling
      if (p == 3) repeat (260) push_event(dbwc_pkg::OP_TIMEOUT, $urandom, sim_now);
      random_traffic(PHASE_WORDS);
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/dbwc_pkg.sv
hdl/dbwc_div.sv
hdl/dbwc_mul.sv
hdl/delay_based_window_controller.sv
dv/tb.sv
